>>> design/cartesian_polar_converter_unit_assert.svh
// assertion macros shared by the checker
`ifndef CARTESIAN_POLAR_CONVERTER_UNIT_ASSERT_SVH
`define CARTESIAN_POLAR_CONVERTER_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define CPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpc check failed");

// condition implies consequence in the next cycle
`define CPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpc check failed");

`endif

>>> design/cpc_pkg.sv
package cpc_pkg;

  // largest number of micro-rotations the arctangent table covers
  localparam int MAX_ITER = 24;

  // 1/K in Q30
  localparam logic signed [30:0] KINV = 31'sd652032874;

  // shift that undoes the Q30 gain and Q8 fraction
  localparam int OUT_SHIFT = 38;

  // atan(2^-i), 2^32 = full circle
  localparam logic [31:0] ATAN_TAB [MAX_ITER] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // control travelling beside each item
  typedef struct packed {
    logic valid;
    logic cmd;     // 0 = cartesian to polar, 1 = polar to cartesian
    logic origin;  // cartesian input at (0,0)
    logic last;
  } ctl_t;

  localparam logic CMD_TO_POLAR = 1'b0;
  localparam logic CMD_TO_RECT  = 1'b1;

endpackage

>>> design/cpc_cell.sv
module cpc_cell #(
  parameter int XW = 35,
  parameter int SHIFT = 0,
  parameter logic [31:0] ATAN = 32'd0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  cpc_pkg::ctl_t        ctl_in,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic [31:0]          z_in,
  output cpc_pkg::ctl_t        ctl_out,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic [31:0]          z_out
);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic                 down;

  // rotation direction: vectoring follows y, rotation follows z
  assign dx = y_in >>> SHIFT;
  assign dy = x_in >>> SHIFT;
  assign down = (ctl_in.cmd == cpc_pkg::CMD_TO_POLAR) ? !y_in[XW-1] : z_in[31];

  // one micro-rotation per cycle while en is high
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
    if (en) begin
      if (down) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN;
      end
    end
  end

endmodule

>>> design/cpc_post.sv
module cpc_post #(
  parameter int XW = 35,
  parameter int DATA_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  cpc_pkg::ctl_t        ctl_in,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic [31:0]          z_in,
  output cpc_pkg::ctl_t        ctl_out,
  output logic [16:0]          result_a,
  output logic [15:0]          result_b
);

  localparam int QW = XW - DATA_WIDTH + 8;
  localparam int PW = QW + 31;
  localparam logic signed [PW-1:0] RND = PW'(64'd1 << (cpc_pkg::OUT_SHIFT - 1));

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [QW-1:0] qx;
  logic signed [QW-1:0] qy;

  cpc_pkg::ctl_t        ctl_m;
  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;
  logic [31:0]          zm;

  logic signed [PW-1:0] rx;
  logic signed [PW-1:0] ry;
  logic signed [PW-cpc_pkg::OUT_SHIFT-1:0] sx;
  logic signed [PW-cpc_pkg::OUT_SHIFT-1:0] sy;
  logic [31:0]          zr;
  logic [15:0]          yb;

  // floor to q8
  assign xs = x_in >>> (DATA_WIDTH - 8);
  assign ys = y_in >>> (DATA_WIDTH - 8);
  assign qx = xs[QW-1:0];
  assign qy = ys[QW-1:0];

  // round half up and drop the fraction
  assign rx = px + RND;
  assign ry = py + RND;
  assign sx = rx[PW-1:cpc_pkg::OUT_SHIFT];
  assign sy = ry[PW-1:cpc_pkg::OUT_SHIFT];
  assign zr = zm + 32'h0000_8000;

  // saturate y to 16 bits
  always_comb begin
    if (sy > (PW-cpc_pkg::OUT_SHIFT)'(32767)) begin
      yb = 16'h7fff;
    end else if (sy < -(PW-cpc_pkg::OUT_SHIFT)'(32768)) begin
      yb = 16'h8000;
    end else begin
      yb = sy[15:0];
    end
  end

  // gain correction multiply, then rounding and output selection
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_m   <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl_m   <= ctl_in;
      ctl_out <= ctl_m;
    end
    if (en) begin
      px <= qx * cpc_pkg::KINV;
      py <= qy * cpc_pkg::KINV;
      zm <= z_in;
      if (ctl_m.origin) begin
        result_a <= '0;
        result_b <= '0;
      end else if (ctl_m.cmd == cpc_pkg::CMD_TO_POLAR) begin
        result_a <= sx[16:0];
        result_b <= zr[31:16];
      end else begin
        result_a <= sx[16:0];
        result_b <= yb;
      end
    end
  end

endmodule

>>> design/cartesian_polar_converter_unit.sv
// Cartesian/polar point converter. Command 0 (s_tuser) turns x,y into
// magnitude and a full-circle angle, command 1 turns radius and angle into
// x,y; angles are binary units with 32768 = pi. The CORDIC is unrolled
// into a chain of ITERATIONS cells (at most MAX_ITER), one micro-rotation
// each, so one item is taken every clock cycle while s_tready is high. An
// accepted item passes through the input folding register, which loads at
// the accepting edge, then the cell chain, a gain-correction multiply
// stage, a rounding stage and the output register. A spare output slot
// keeps the chain moving while a result waits; s_tready drops only once
// that slot is also full.
module cartesian_polar_converter_unit #(
  parameter int ITERATIONS = 16,
  parameter int DATA_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // coord_a [15:0], coord_b [31:16]
  input  logic        s_tuser,   // command
  input  logic        s_tlast,   // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // result_a [16:0], result_b [32:17], zero [39:33]
  output logic        m_tlast    // last_point_out
);

  localparam int NCELL = (ITERATIONS > cpc_pkg::MAX_ITER) ? cpc_pkg::MAX_ITER : ITERATIONS;
  localparam int XW = DATA_WIDTH + 19;

  logic                 en;
  logic signed [15:0]   a;
  logic signed [15:0]   b;
  logic signed [XW-1:0] ax;
  logic signed [XW-1:0] by;
  logic                 flip;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  logic [31:0]          z0;

  cpc_pkg::ctl_t        fold_ctl;
  logic signed [XW-1:0] fold_x;
  logic signed [XW-1:0] fold_y;
  logic [31:0]          fold_z;

  cpc_pkg::ctl_t        cctl [NCELL+1];
  logic signed [XW-1:0] cx [NCELL+1];
  logic signed [XW-1:0] cy [NCELL+1];
  logic [31:0]          cz [NCELL+1];

  cpc_pkg::ctl_t        pctl;
  logic [16:0]          pa;
  logic [15:0]          pb;

  logic                 skid_valid;
  logic [16:0]          skid_a;
  logic [15:0]          skid_b;
  logic                 skid_last;
  logic [16:0]          out_a;
  logic [15:0]          out_b;
  logic                 load;

  // whole chain moves unless the spare slot is holding an item
  assign en = !skid_valid;
  assign s_tready = en;

  // input unpacking and q(DATA_WIDTH) scaling
  assign a  = s_tdata[15:0];
  assign b  = s_tdata[31:16];
  assign ax = {{(XW-16-DATA_WIDTH){a[15]}}, a, {DATA_WIDTH{1'b0}}};
  assign by = {{(XW-16-DATA_WIDTH){b[15]}}, b, {DATA_WIDTH{1'b0}}};
  assign flip = b[15] ^ b[14];

  // quadrant folding into the cordic range
  always_comb begin
    if (s_tuser == cpc_pkg::CMD_TO_POLAR) begin
      x0 = a[15] ? -ax : ax;
      y0 = a[15] ? -by : by;
      z0 = a[15] ? 32'h8000_0000 : 32'h0;
    end else begin
      x0 = flip ? -ax : ax;
      y0 = '0;
      z0 = {b[15] ^ flip, b[14:0], 16'h0};
    end
  end

  // folding stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_ctl <= '0;
    end else if (en) begin
      fold_ctl.valid  <= s_tvalid;
      fold_ctl.cmd    <= s_tuser;
      fold_ctl.origin <= (s_tuser == cpc_pkg::CMD_TO_POLAR) && (a == 16'sd0) && (b == 16'sd0);
      fold_ctl.last   <= s_tlast;
    end
    if (en) begin
      fold_x <= x0;
      fold_y <= y0;
      fold_z <= z0;
    end
  end

  // head of the chain
  assign cctl[0] = fold_ctl;
  assign cx[0]   = fold_x;
  assign cy[0]   = fold_y;
  assign cz[0]   = fold_z;

  // chain of micro-rotation cells
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cpc_cell #(
      .XW(XW),
      .SHIFT(i),
      .ATAN(cpc_pkg::ATAN_TAB[i])
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .en(en),
      .ctl_in(cctl[i]),
      .x_in(cx[i]),
      .y_in(cy[i]),
      .z_in(cz[i]),
      .ctl_out(cctl[i+1]),
      .x_out(cx[i+1]),
      .y_out(cy[i+1]),
      .z_out(cz[i+1])
    );
  end

  // gain correction and rounding
  cpc_post #(
    .XW(XW),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_post (
    .clk(clk),
    .rst(rst),
    .en(en),
    .ctl_in(cctl[NCELL]),
    .x_in(cx[NCELL]),
    .y_in(cy[NCELL]),
    .z_in(cz[NCELL]),
    .ctl_out(pctl),
    .result_a(pa),
    .result_b(pb)
  );

  // output register with one spare slot
  assign load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= pctl.valid;
      end
    end else if (en && pctl.valid) begin
      skid_valid <= 1'b1;
    end
    if (load) begin
      if (skid_valid) begin
        out_a   <= skid_a;
        out_b   <= skid_b;
        m_tlast <= skid_last;
      end else begin
        out_a   <= pa;
        out_b   <= pb;
        m_tlast <= pctl.last;
      end
    end else if (en) begin
      skid_a    <= pa;
      skid_b    <= pb;
      skid_last <= pctl.last;
    end
  end

  assign m_tdata = {7'b0, out_b, out_a};

endmodule

>>> design/cpc_checker.sv
`include "cartesian_polar_converter_unit_assert.svh"

module cpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // a stalled result holds
  `CPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // input side blocks only while a result is waiting
  `CPC_ASSERT_NOW(a_block_needs_result, !s_tready, m_tvalid)

  // input side closes only after an output stall
  `CPC_ASSERT_NOW(a_block_after_stall, $fell(s_tready), $past(m_tvalid && !m_tready))

  // padding bits of the result stay zero
  `CPC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[39:33] == 7'b0)

endmodule

bind cartesian_polar_converter_unit cpc_checker u_cpc_checker (.*);

>>> dv/cartesian_polar_converter_unit_test.sv
module cartesian_polar_converter_unit_test;
  import cpc_pkg::*;

  localparam int ITERATIONS = 16;
  localparam int DATA_WIDTH = 16;
  localparam int ROTATIONS = (ITERATIONS < MAX_ITER) ? ITERATIONS : MAX_ITER;
  localparam int LATENCY = ITERATIONS + 3;
  localparam int RANDOM_ITEMS = 1200;
  localparam int NUM_DIRECTED = 24;

  // one converted point as it leaves the block
  typedef struct packed {
    logic signed [16:0] mag_x;  // magnitude, or x
    logic signed [15:0] ang_y;  // angle, or y
    logic               last;
  } point_result_t;

  // one point to send, with a typed-in result where it is obvious
  typedef struct packed {
    logic               cmd;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               last;
    logic               known;
    logic signed [16:0] fa;
    logic signed [15:0] fb;
  } stim_row_t;

  localparam logic Y = 1'b1;
  localparam logic N = 1'b0;
  localparam logic signed [15:0] MIN16 = 16'sh8000;
  localparam logic signed [15:0] MAX16 = 16'sh7fff;

  // directed points: extremes, both commands, origin, half planes, quadrants
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    // origin and zero radius give all zeros
    '{CMD_TO_POLAR, 16'sd0, 16'sd0, 1'b0, Y, 17'sd0, 16'sd0},
    '{CMD_TO_RECT, 16'sd0, 16'sd12345, 1'b1, Y, 17'sd0, 16'sd0},
    '{CMD_TO_RECT, 16'sd0, MIN16, 1'b0, Y, 17'sd0, 16'sd0},
    // corners of the cartesian range
    '{CMD_TO_POLAR, MAX16, MAX16, 1'b0, N, 17'sd0, 16'sd0},
    '{CMD_TO_POLAR, MIN16, MIN16, 1'b1, N, 17'sd0, 16'sd0},
    '{CMD_TO_POLAR, MIN16, MAX16, 1'b0, N, 17'sd0, 16'sd0},
    '{CMD_TO_POLAR, MAX16, MIN16, 1'b0, N, 17'sd0, 16'sd0},
    // left half plane, angle pi wraps to the most negative code
    '{CMD_TO_POLAR, -16'sd100, 16'sd0, 1'b0, N, 17'sd0, 16'sd0},
    '{CMD_TO_POLAR, -16'sd1, 16'sd0, 1'b1, N, 17'sd0, 16'sd0},
    '{CMD_TO_POLAR, MIN16, 16'sd1, 1'b0, N, 17'sd0, 16'sd0},
    // on the y axis and near the origin
    '{CMD_TO_POLAR, 16'sd0, MAX16, 1'b0, N, 17'sd0, 16'sd0},
    '{CMD_TO_POLAR, 16'sd0, MIN16, 1'b0, N, 17'sd0, 16'sd0},
    '{CMD_TO_POLAR, 16'sd1, 16'sd0, 1'b0, N, 17'sd0, 16'sd0},
    '{CMD_TO_POLAR, 16'sd0, -16'sd1, 1'b0, N, 17'sd0, 16'sd0},
    // polar, first and fourth quadrant
    '{CMD_TO_RECT, MAX16, 16'sd0, 1'b0, N, 17'sd0, 16'sd0},
    '{CMD_TO_RECT, MAX16, 16'sd16384, 1'b0, N, 17'sd0, 16'sd0},
    '{CMD_TO_RECT, MAX16, -16'sd16384, 1'b1, N, 17'sd0, 16'sd0},
    '{CMD_TO_RECT, MAX16, 16'sd8192, 1'b0, N, 17'sd0, 16'sd0},
    // wide angles handled as negated radius
    '{CMD_TO_RECT, MAX16, MIN16, 1'b0, N, 17'sd0, 16'sd0},
    '{CMD_TO_RECT, MAX16, 16'sd24576, 1'b0, N, 17'sd0, 16'sd0},
    '{CMD_TO_RECT, 16'sd20000, -16'sd24576, 1'b0, N, 17'sd0, 16'sd0},
    // negative radius, and y that overflows and saturates
    '{CMD_TO_RECT, MIN16, 16'sd0, 1'b0, N, 17'sd0, 16'sd0},
    '{CMD_TO_RECT, MIN16, -16'sd16384, 1'b1, N, 17'sd0, 16'sd0},
    '{CMD_TO_RECT, MIN16, 16'sd8191, 1'b0, N, 17'sd0, 16'sd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // coord_a [15:0], coord_b [31:16]
  logic        s_tuser = 1'b0; // command
  logic        s_tlast = 1'b0; // last_point
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // result_a [16:0], result_b [32:17], zero [39:33]
  logic        m_tlast;        // last_point_out

  // typed-in result riding beside the item on the input side
  logic          row_known = 1'b0;
  point_result_t row_result = '0;

  point_result_t results_due [$];
  point_result_t want;
  int            mismatch_count = 0;
  int            burst_left = 0;
  int            sent = 0;

  cartesian_polar_converter_unit #(
    .ITERATIONS(ITERATIONS),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // remove the cordic gain: floor to q8, multiply by 1/k, round half up
  function automatic longint remove_gain(input longint v);
    longint q;
    longint p;
    q = v >>> (DATA_WIDTH - 8);
    p = q * longint'(KINV) + (longint'(1) <<< (OUT_SHIFT - 1));
    return p >>> OUT_SHIFT;
  endfunction

  // expected conversion of one point
  function automatic point_result_t convert_point(input logic cmd,
                                                  input logic signed [15:0] a,
                                                  input logic signed [15:0] b,
                                                  input logic last);
    longint        one;
    longint        x;
    longint        y;
    longint        dx;
    longint        dy;
    longint        ra;
    longint        rb;
    bit [31:0]     ang;
    bit [31:0]     rounded;
    point_result_t r;
    one = longint'(1) <<< DATA_WIDTH;
    x = longint'(a) * one;
    if (cmd == CMD_TO_POLAR) begin
      // vectoring: drive y to zero, accumulate the angle
      y = longint'(b) * one;
      ang = 32'h0;
      if (x < 0) begin
        x = -x;
        y = -y;
        ang = 32'h8000_0000;
      end
      for (int i = 0; i < ROTATIONS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          ang = ang + ATAN_TAB[i];
        end else begin
          x = x - dx;
          y = y + dy;
          ang = ang - ATAN_TAB[i];
        end
      end
      if (a == 0 && b == 0) begin
        ra = 0;
        rb = 0;
      end else begin
        ra = remove_gain(x);
        rounded = ang + 32'h8000;
        rb = longint'(rounded[31:16]);
      end
    end else begin
      // rotation: start on the x axis, turn by the angle
      y = 0;
      ang = {b, 16'h0};
      if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
        x = -x;
        ang = ang + 32'h8000_0000;
      end
      for (int i = 0; i < ROTATIONS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (!ang[31]) begin
          x = x - dx;
          y = y + dy;
          ang = ang - ATAN_TAB[i];
        end else begin
          x = x + dx;
          y = y - dy;
          ang = ang + ATAN_TAB[i];
        end
      end
      ra = remove_gain(x);
      rb = remove_gain(y);
      if (rb > 32767) rb = 32767;
      if (rb < -32768) rb = -32768;
    end
    r.mag_x = ra[16:0];
    r.ang_y = rb[15:0];
    r.last = last;
    return r;
  endfunction

  // offer one item, with bursts and gaps that change every few hundred items
  task automatic send_item(input stim_row_t row);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      case ((sent / 300) % 4)
        0: begin
          burst_left = 300 - (sent % 300);
        end
        1: begin
          burst_left = $urandom_range(1, 24);
          gap = $urandom_range(1, 4);
        end
        2: begin
          burst_left = $urandom_range(4, 40);
          gap = $urandom_range(1, 12);
        end
        default: begin
          burst_left = $urandom_range(1, 3);
          gap = $urandom_range(0, 1);
        end
      endcase
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {row.b, row.a};
    s_tuser <= row.cmd;
    s_tlast <= row.last;
    row_known <= row.known;
    row_result <= '{mag_x: row.fa, ang_y: row.fb, last: row.last};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  // record accepted items and check results in order
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (row_known)
          results_due.push_back(row_result);
        else
          results_due.push_back(convert_point(s_tuser, s_tdata[15:0], s_tdata[31:16],
                                              s_tlast));
      end
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected item, actual %h", $time, m_tdata);
        end else begin
          want = results_due.pop_front();
          if (m_tdata[16:0] !== want.mag_x) begin
            mismatch_count++;
            $display("%0t: result_a expected %0d actual %0d", $time,
                     $signed(want.mag_x), $signed(m_tdata[16:0]));
          end
          if (m_tdata[32:17] !== want.ang_y) begin
            mismatch_count++;
            $display("%0t: result_b expected %0d actual %0d", $time,
                     $signed(want.ang_y), $signed(m_tdata[32:17]));
          end
          if (m_tlast !== want.last) begin
            mismatch_count++;
            $display("%0t: last_point_out expected %0b actual %0b", $time,
                     want.last, m_tlast);
          end
          if (m_tdata[39:33] !== 7'h0) begin
            mismatch_count++;
            $display("%0t: pad bits expected 0 actual %h", $time, m_tdata[39:33]);
          end
        end
      end
    end
  end

  // receiver: changing stall patterns, plus long hold-offs that back up the pipe
  initial begin : receiver
    int cyc;
    int hold;
    cyc = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 400 || cyc == 2500) hold = 120;
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        case ((cyc / 250) % 4)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ((cyc % 5) < 3);
        endcase
      end
    end
  end

  // main sequence
  initial begin : stimulus
    stim_row_t row;
    int        kind;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < NUM_DIRECTED; k++) send_item(DIRECTED[k]);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      row = '0;
      row.cmd = 1'($urandom_range(0, 1));
      row.a = 16'($urandom);
      row.b = 16'($urandom);
      kind = $urandom_range(0, 9);
      case (kind)
        // points close to the origin
        0, 1: begin
          row.a = 16'($urandom_range(0, 63)) - 16'sd32;
          row.b = 16'($urandom_range(0, 63)) - 16'sd32;
        end
        // on an axis
        2: begin
          if ($urandom_range(0, 1) == 1) row.a = 16'sd0;
          else row.b = 16'sd0;
        end
        // range extremes
        3: begin
          row.a = ($urandom_range(0, 1) == 1) ? MAX16 : MIN16;
          case ($urandom_range(0, 2))
            0: row.b = MAX16;
            1: row.b = MIN16;
            default: row.b = 16'sd0;
          endcase
        end
        // proper polar points with a non-negative radius
        4, 5: begin
          row.cmd = CMD_TO_RECT;
          row.a = 16'($urandom_range(0, 32767));
        end
        default: begin
        end
      endcase
      row.last = ($urandom_range(0, 7) == 0);
      send_item(row);
    end
    s_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
